// File: hdl/sjv_pkg.sv
// Shared constants and types for the Shift-JIS string validator.
// Used by the top level and by its port checker; depends on nothing.
package sjv_pkg;

  // Width of the byte position counter
  localparam int POSITION_BITS = 16;
  // Width of the length limit register
  localparam int LEN_BITS = 16;
  // Width at which position and limit are compared
  localparam int CMP_BITS = (POSITION_BITS > LEN_BITS) ? POSITION_BITS : LEN_BITS;

  typedef logic [POSITION_BITS-1:0] position_t;
  typedef logic [LEN_BITS-1:0]      length_t;
  typedef logic [CMP_BITS-1:0]      cmp_t;
  typedef logic [7:0]               byte_t;

  // Verdict codes
  typedef logic [1:0] verdict_t;
  localparam verdict_t V_PENDING = 2'd0;
  localparam verdict_t V_VALID   = 2'd1;
  localparam verdict_t V_INVALID = 2'd2;
  localparam verdict_t V_IGNORED = 2'd3;

  // Byte class ranges
  localparam byte_t LEAD_LO1   = 8'h81;
  localparam byte_t LEAD_HI1   = 8'h9F;
  localparam byte_t LEAD_LO2   = 8'hE0;
  localparam byte_t LEAD_HI2   = 8'hFC;
  localparam byte_t TRAIL_LO1  = 8'h40;
  localparam byte_t TRAIL_HI1  = 8'h7E;
  localparam byte_t TRAIL_LO2  = 8'h80;
  localparam byte_t TRAIL_HI2  = 8'hFC;
  localparam byte_t SINGLE_LO1 = 8'h09;
  localparam byte_t SINGLE_HI1 = 8'h0D;
  localparam byte_t SINGLE_LO2 = 8'h20;
  localparam byte_t SINGLE_HI2 = 8'h7E;

  function automatic logic is_lead(input byte_t b);
    return (b >= LEAD_LO1 && b <= LEAD_HI1) || (b >= LEAD_LO2 && b <= LEAD_HI2);
  endfunction

  function automatic logic is_trail(input byte_t b);
    return (b >= TRAIL_LO1 && b <= TRAIL_HI1) || (b >= TRAIL_LO2 && b <= TRAIL_HI2);
  endfunction

  function automatic logic is_single(input byte_t b);
    return (b >= SINGLE_LO1 && b <= SINGLE_HI1) || (b >= SINGLE_LO2 && b <= SINGLE_HI2);
  endfunction

endpackage

// File: hdl/shift_jis_string_validator.sv
// Shift-JIS string validator: one verdict per input byte.
// Depends on sjv_pkg for constants, byte classes and verdict codes.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_stall    first, data_byte
//   out      from block out_valid / out_stall  verdict
//   cfg      to block   cfg_wen                cfg_wdata (max_length)
//
// One byte is accepted per cycle while in_stall is low; its verdict is registered.
// The verdict comes from range compares and a saturating add on the
// position counter between the state registers and the result register.
// A skid register holds one extra verdict while out is stalled; in_stall
// rises only when both are full. Synchronous reset clears phase, position,
// the limit and both valid flags.
module shift_jis_string_validator (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    first,
  input  logic [7:0]              data_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              verdict,
  input  logic                    cfg_wen,
  input  logic [sjv_pkg::LEN_BITS-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_TRAIL = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  phase_t              phase;
  phase_t              phase_next;
  sjv_pkg::position_t  position;
  sjv_pkg::position_t  position_next;
  sjv_pkg::length_t    max_length;
  sjv_pkg::verdict_t   verdict_next;
  sjv_pkg::verdict_t   skid_verdict;
  logic                skid_valid;

  phase_t                     cur_phase;
  sjv_pkg::position_t         cur_pos;
  logic [sjv_pkg::POSITION_BITS:0] pos_sum;
  logic [1:0]                 pos_inc;
  logic                       limit_hit;
  logic                       in_acc;
  logic                       out_take;

  assign in_acc   = in_valid & ~in_stall;
  assign out_take = out_valid & ~out_stall;
  assign in_stall = skid_valid;

  // Restart the check on a start mark
  assign cur_phase = first ? PH_LEAD : phase;
  assign cur_pos   = first ? '0 : position;
  assign limit_hit = (max_length != '0) &&
                     (sjv_pkg::cmp_t'(cur_pos) >= sjv_pkg::cmp_t'(max_length));

  // Classify the byte against the current phase
  always_comb begin
    phase_next   = cur_phase;
    verdict_next = sjv_pkg::V_PENDING;
    pos_inc      = 2'd0;
    unique case (cur_phase)
      PH_LEAD: begin
        if (data_byte == 8'h00) begin
          verdict_next = sjv_pkg::V_VALID;
          phase_next   = PH_DONE;
        end else if (limit_hit) begin
          verdict_next = sjv_pkg::V_INVALID;
          phase_next   = PH_DONE;
        end else if (sjv_pkg::is_lead(data_byte)) begin
          phase_next   = PH_TRAIL;
        end else if (sjv_pkg::is_single(data_byte)) begin
          pos_inc      = 2'd1;
        end else begin
          verdict_next = sjv_pkg::V_INVALID;
          phase_next   = PH_DONE;
        end
      end
      PH_TRAIL: begin
        if (sjv_pkg::is_trail(data_byte)) begin
          pos_inc    = 2'd2;
          phase_next = PH_LEAD;
        end else begin
          verdict_next = sjv_pkg::V_INVALID;
          phase_next   = PH_DONE;
        end
      end
      default: begin
        verdict_next = sjv_pkg::V_IGNORED;
      end
    endcase
  end

  // Advance the position, holding at all ones
  assign pos_sum = {1'b0, cur_pos} + (sjv_pkg::POSITION_BITS+1)'(pos_inc);
  assign position_next = pos_sum[sjv_pkg::POSITION_BITS] ? '1
                                                         : pos_sum[sjv_pkg::POSITION_BITS-1:0];

  // Hold state, limit, result and skid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEAD;
      position   <= '0;
      max_length <= '0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        max_length <= cfg_wdata;
      end
      if (in_acc) begin
        phase    <= phase_next;
        position <= position_next;
      end
      // Result register: refill from skid or from the new item
      if (out_take) begin
        if (skid_valid) begin
          verdict <= skid_verdict;
        end else if (in_acc) begin
          verdict <= verdict_next;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (!out_valid && in_acc) begin
        verdict   <= verdict_next;
        out_valid <= 1'b1;
      end
      // Skid register: catch an item while the result is stalled
      if (in_acc && out_valid && !out_take) begin
        skid_verdict <= verdict_next;
        skid_valid   <= 1'b1;
      end else if (out_take) begin
        skid_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/sjv_checker.sv
// Port-level checker for the Shift-JIS string validator, bound to the top.
// Depends on sjv_pkg for verdict codes.
module sjv_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       first,
  input logic [7:0] data_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] verdict
);

  // Input stalls only while a result is waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("in_stall high with no result pending");

  // Hold a stalled result
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(verdict)))
    else $error("stalled result changed or dropped");

  // Come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("block not empty after reset");

  // Terminator on a fresh string gives valid on the next cycle
  a_zero_start_valid: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && first && data_byte == 8'h00 &&
     (!out_valid || !out_stall))
    |=> (out_valid && verdict == sjv_pkg::V_VALID))
    else $error("terminator at start did not yield valid");

endmodule

bind shift_jis_string_validator sjv_checker u_sjv_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .first     (first),
  .data_byte (data_byte),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .verdict   (verdict)
);

// File: verif/sjv_verdict_checker.sv
// Verdict checker for the Shift-JIS string validator: watches the byte,
// verdict and limit ports, predicts each verdict and compares in order.
// Depends on sjv_pkg for widths and verdict codes.
`timescale 1ns / 1ps

module sjv_verdict_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 first,
  input  sjv_pkg::byte_t       data_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  sjv_pkg::verdict_t    verdict,
  input  logic                 cfg_wen,
  input  sjv_pkg::length_t     cfg_wdata,
  output int                   mismatches,
  output int                   verdicts_owed,
  output int                   valid_count,
  output int                   invalid_count,
  output int                   ignored_count
);

  typedef enum logic [1:0] {
    SCAN_LEAD  = 2'd0,
    SCAN_TRAIL = 2'd1,
    SCAN_DONE  = 2'd2
  } scan_phase_t;

  scan_phase_t        scan_phase;
  sjv_pkg::position_t byte_pos;
  sjv_pkg::length_t   len_limit;
  sjv_pkg::verdict_t  expected_verdicts[$];
  int                 fail_tally;
  int                 n_valid;
  int                 n_invalid;
  int                 n_ignored;

  // Byte classes of the encoding
  function automatic bit kanji_lead(sjv_pkg::byte_t b);
    return (b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc);
  endfunction

  function automatic bit kanji_trail(sjv_pkg::byte_t b);
    return (b >= 8'h40 && b <= 8'h7e) || (b >= 8'h80 && b <= 8'hfc);
  endfunction

  function automatic bit plain_char(sjv_pkg::byte_t b);
    return (b >= 8'h09 && b <= 8'h0d) || (b >= 8'h20 && b <= 8'h7e);
  endfunction

  // Add to the position, holding at all ones
  function automatic sjv_pkg::position_t advance_pos(sjv_pkg::position_t p, int unsigned n);
    logic [sjv_pkg::POSITION_BITS:0] sum;
    sum = {1'b0, p} + n[sjv_pkg::POSITION_BITS:0];
    if (sum[sjv_pkg::POSITION_BITS]) begin
      return '1;
    end
    return sum[sjv_pkg::POSITION_BITS-1:0];
  endfunction

  // Advance the scan by one byte and return its verdict
  function sjv_pkg::verdict_t judge_byte(logic start, sjv_pkg::byte_t b);
    sjv_pkg::verdict_t v;
    if (start) begin
      scan_phase = SCAN_LEAD;
      byte_pos   = '0;
    end
    case (scan_phase)
      SCAN_LEAD: begin
        if (b == 8'h00) begin
          v = sjv_pkg::V_VALID;
          scan_phase = SCAN_DONE;
        end else if (len_limit != '0 &&
                     sjv_pkg::cmp_t'(byte_pos) >= sjv_pkg::cmp_t'(len_limit)) begin
          v = sjv_pkg::V_INVALID;
          scan_phase = SCAN_DONE;
        end else if (kanji_lead(b)) begin
          v = sjv_pkg::V_PENDING;
          scan_phase = SCAN_TRAIL;
        end else if (plain_char(b)) begin
          v = sjv_pkg::V_PENDING;
          byte_pos = advance_pos(byte_pos, 1);
        end else begin
          v = sjv_pkg::V_INVALID;
          scan_phase = SCAN_DONE;
        end
      end
      SCAN_TRAIL: begin
        if (kanji_trail(b)) begin
          v = sjv_pkg::V_PENDING;
          byte_pos = advance_pos(byte_pos, 2);
          scan_phase = SCAN_LEAD;
        end else begin
          v = sjv_pkg::V_INVALID;
          scan_phase = SCAN_DONE;
        end
      end
      default: begin
        v = sjv_pkg::V_IGNORED;
      end
    endcase
    return v;
  endfunction

  // Compare each delivered verdict with the oldest one predicted, then
  // predict for the item accepted at this edge
  always @(posedge clk) begin
    sjv_pkg::verdict_t want;
    if (rst) begin
      scan_phase = SCAN_LEAD;
      byte_pos   = '0;
      len_limit  = '0;
      fail_tally = 0;
      n_valid    = 0;
      n_invalid  = 0;
      n_ignored  = 0;
      expected_verdicts.delete();
      mismatches    <= 0;
      verdicts_owed <= 0;
      valid_count   <= 0;
      invalid_count <= 0;
      ignored_count <= 0;
    end else begin
      if (cfg_wen) begin
        len_limit = cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: verdict %0d delivered with none expected", $time, verdict);
          fail_tally++;
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict !== want) begin
            $display("%0t: verdict mismatch, expected %0d, actual %0d", $time, want, verdict);
            fail_tally++;
          end
          case (want)
            sjv_pkg::V_VALID:   n_valid++;
            sjv_pkg::V_INVALID: n_invalid++;
            sjv_pkg::V_IGNORED: n_ignored++;
            default:   ;
          endcase
        end
      end
      if (in_valid && !in_stall) begin
        expected_verdicts.push_back(judge_byte(first, data_byte));
      end
      mismatches    <= fail_tally;
      verdicts_owed <= expected_verdicts.size();
      valid_count   <= n_valid;
      invalid_count <= n_invalid;
      ignored_count <= n_ignored;
    end
  end

endmodule

// File: verif/shift_jis_string_validator_tb.sv
// Testbench top for the Shift-JIS string validator: drives bytes, the
// length limit and output stall, and reports the verdict of the run.
// Depends on sjv_pkg, shift_jis_string_validator and sjv_verdict_checker.
`timescale 1ns / 1ps

module shift_jis_string_validator_tb;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int BLOCKS_PER_PHASE = 5;
  localparam int BYTES_PER_BLOCK  = 100;
  localparam int LONG_PAIRS       = 24;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic              first     = 1'b0;
  sjv_pkg::byte_t    data_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  sjv_pkg::verdict_t verdict;
  logic              cfg_wen   = 1'b0;
  sjv_pkg::length_t  cfg_wdata = '0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int cycle_count   = 0;
  int bytes_sent    = 0;
  int mismatches;
  int verdicts_owed;
  int valid_count;
  int invalid_count;
  int ignored_count;

  shift_jis_string_validator u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .first     (first),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .verdict   (verdict),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  sjv_verdict_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .first         (first),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .verdict       (verdict),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .verdicts_owed (verdicts_owed),
    .valid_count   (valid_count),
    .invalid_count (invalid_count),
    .ignored_count (ignored_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the verdict channel at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("shift_jis_string_validator test failed");
      $finish;
    end
  end

  // Offer one item and hold it until accepted
  task automatic send_byte(logic start, sjv_pkg::byte_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    first     <= start;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  // Drop valid and wait for every verdict owed
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_owed != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_limit(sjv_pkg::length_t value);
    settle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  function automatic sjv_pkg::byte_t random_lead();
    if ($urandom_range(0, 1) != 0) begin
      return sjv_pkg::byte_t'($urandom_range(sjv_pkg::LEAD_LO1, sjv_pkg::LEAD_HI1));
    end
    return sjv_pkg::byte_t'($urandom_range(sjv_pkg::LEAD_LO2, sjv_pkg::LEAD_HI2));
  endfunction

  function automatic sjv_pkg::byte_t random_trail();
    if ($urandom_range(0, 1) != 0) begin
      return sjv_pkg::byte_t'($urandom_range(sjv_pkg::TRAIL_LO1, sjv_pkg::TRAIL_HI1));
    end
    return sjv_pkg::byte_t'($urandom_range(sjv_pkg::TRAIL_LO2, sjv_pkg::TRAIL_HI2));
  endfunction

  // Send one string of random characters, mostly well formed; a broken one
  // carries junk bytes, bad trail bytes or stray restarts
  task automatic send_random_string(output int counted);
    int             nchars;
    bit             broken;
    logic           mark;
    sjv_pkg::byte_t b;
    counted = 0;
    mark    = 1'b1;
    nchars  = $urandom_range(0, 10);
    broken  = ($urandom_range(0, 99) < 20);
    for (int i = 0; i < nchars; i++) begin
      if (broken && $urandom_range(0, nchars) == 0) begin
        send_byte(mark || ($urandom_range(0, 1) != 0),
                  sjv_pkg::byte_t'($urandom_range(0, 255)));
        mark = 1'b0;
        counted++;
      end
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 5) == 0) begin
          b = sjv_pkg::byte_t'($urandom_range(sjv_pkg::SINGLE_LO1, sjv_pkg::SINGLE_HI1));
        end else begin
          b = sjv_pkg::byte_t'($urandom_range(sjv_pkg::SINGLE_LO2, sjv_pkg::SINGLE_HI2));
        end
        send_byte(mark, b);
        counted++;
      end else begin
        send_byte(mark, random_lead());
        if (broken && $urandom_range(0, 3) == 0) begin
          b = sjv_pkg::byte_t'($urandom_range(0, 255));
        end else begin
          b = random_trail();
        end
        send_byte(1'b0, b);
        counted += 2;
      end
      mark = 1'b0;
    end
    if (!broken || $urandom_range(0, 1) != 0) begin
      send_byte(mark, 8'h00);
      counted++;
    end
    // Trail off with random bytes, ignored once the string has a verdict
    repeat ($urandom_range(0, 2)) begin
      send_byte(1'b0, sjv_pkg::byte_t'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int counted;
    int got;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 8;
    stall_pct     = 87;

    // Directed: reset limit of zero, no start mark on the first byte
    send_byte(1'b0, 8'h41);
    send_byte(1'b0, sjv_pkg::SINGLE_LO1);
    send_byte(1'b0, sjv_pkg::SINGLE_HI1);
    send_byte(1'b0, sjv_pkg::SINGLE_LO2);
    send_byte(1'b0, sjv_pkg::SINGLE_HI2);
    send_byte(1'b0, sjv_pkg::LEAD_LO1);
    send_byte(1'b0, sjv_pkg::TRAIL_LO1);
    send_byte(1'b0, sjv_pkg::LEAD_HI1);
    send_byte(1'b0, sjv_pkg::TRAIL_HI1);
    send_byte(1'b0, sjv_pkg::LEAD_LO2);
    send_byte(1'b0, sjv_pkg::TRAIL_LO2);
    send_byte(1'b0, sjv_pkg::LEAD_HI2);
    send_byte(1'b0, sjv_pkg::TRAIL_HI2);
    send_byte(1'b0, 8'h00);
    // Ignored after the verdict, then restarted by a start mark
    send_byte(1'b0, 8'hff);
    send_byte(1'b1, 8'h08);
    // Zero and out-of-range trail bytes
    send_byte(1'b1, 8'h81);
    send_byte(1'b0, 8'h00);
    send_byte(1'b1, 8'hfc);
    send_byte(1'b0, 8'hfd);
    send_byte(1'b1, 8'he0);
    send_byte(1'b0, 8'h7f);
    // Bytes that are neither lead nor single, and a restart mid-string
    send_byte(1'b1, 8'ha0);
    send_byte(1'b1, 8'h41);
    send_byte(1'b1, 8'h00);

    // Limit of one: the second lead position is out of range
    write_limit(16'd1);
    send_byte(1'b1, 8'h41);
    send_byte(1'b0, 8'h42);
    send_byte(1'b1, 8'h00);

    // Random strings, idling pattern per phase, new limit per block
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 8;  stall_pct = 87; end
        1: begin send_idle_pct = 87; stall_pct = 8;  end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
        case ($urandom_range(0, 3))
          0:       write_limit('0);
          3:       write_limit(sjv_pkg::length_t'($urandom_range(0, 65535)));
          default: write_limit(sjv_pkg::length_t'($urandom_range(1, 24)));
        endcase
        counted = 0;
        while (counted < BYTES_PER_BLOCK) begin
          send_random_string(got);
          counted += got;
        end
      end
    end

    // Run a long double-byte string under the largest limit, then two
    // single bytes that stay inside it
    write_limit('1);
    for (int i = 0; i < LONG_PAIRS; i++) begin
      send_byte(i == 0, random_lead());
      send_byte(1'b0, random_trail());
    end
    send_byte(1'b0, 8'h41);
    send_byte(1'b0, 8'h41);

    settle();
    repeat (4) @(posedge clk);
    $display("Sent %0d bytes under limits 0, 1, 65535 and random, with stalls on both sides",
             bytes_sent);
    $display("Checked verdicts: %0d valid, %0d invalid, %0d ignored",
             valid_count, invalid_count, ignored_count);
    if (mismatches == 0 && verdicts_owed == 0) begin
      $display("shift_jis_string_validator test passed");
    end else begin
      $display("shift_jis_string_validator test failed");
    end
    $finish;
  end

endmodule

// File: shift_jis_string_validator.f
hdl/sjv_pkg.sv
hdl/shift_jis_string_validator.sv
hdl/sjv_checker.sv
verif/sjv_verdict_checker.sv
verif/shift_jis_string_validator_tb.sv
